[hdl/pf2rgba8_pkg.sv]
// Shared types, constants and format codes for the pixel format to RGBA8 converter.
package pf2rgba8_pkg;

	localparam int unsigned COMP_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned NUM_COMP = 4;
	localparam int unsigned IN_W     = COMP_W * NUM_COMP;
	localparam int unsigned OUT_W    = BYTE_W * NUM_COMP;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	// half-float fields
	localparam int unsigned HALF_MANT_W = 10;
	localparam int unsigned HALF_EXP_W  = 5;
	localparam logic [HALF_EXP_W-1:0] HALF_EXP_MAX = 5'h1f;
	localparam logic [HALF_EXP_W-1:0] HALF_EXP_ONE = 5'd15;
	localparam logic [BYTE_W-1:0]     UNORM_MAX    = 8'hff;

	typedef enum logic [1:0] {
		FMT_RGBA8   = 2'd0,
		FMT_BGRA8   = 2'd1,
		FMT_RGBA16F = 2'd2,
		FMT_NONE    = 2'd3
	} pix_fmt_t;

	typedef enum logic [0:0] {
		REG_PIXEL_FORMAT = 1'b0,
		REG_UNUSED       = 1'b1
	} reg_idx_t;

	typedef logic [COMP_W-1:0] comp_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		comp_t comp3;
		comp_t comp2;
		comp_t comp1;
		comp_t comp0;
	} pix_in_t;

	typedef struct packed {
		byte_t alpha;
		byte_t blue;
		byte_t green;
		byte_t red;
	} pix_out_t;

endpackage

[hdl/pf2rgba8_regs.sv]
// APB configuration register block holding the source pixel format.
module pf2rgba8_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pf2rgba8_pkg::PADDR_W-1:0]    paddr,
	input  logic [pf2rgba8_pkg::PDATA_W-1:0]    pwdata,
	output logic [pf2rgba8_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready,
	output pf2rgba8_pkg::pix_fmt_t              pixel_format
);

	pf2rgba8_pkg::pix_fmt_t   fmt_q;
	pf2rgba8_pkg::reg_idx_t   reg_idx;
	logic                     wr_en;

	assign reg_idx = pf2rgba8_pkg::reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pf2rgba8_pkg::FMT_RGBA8;
		end else if (wr_en && (reg_idx == pf2rgba8_pkg::REG_PIXEL_FORMAT)) begin
			fmt_q <= pf2rgba8_pkg::pix_fmt_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		case (reg_idx)
			pf2rgba8_pkg::REG_PIXEL_FORMAT: prdata = {30'd0, fmt_q};
			default:                        prdata = '0;
		endcase
	end

	assign pixel_format = fmt_q;

endmodule

[hdl/pf2rgba8_half_cvt.sv]
// Converts one binary16 component to an unsigned normalized byte with exact rounding.
module pf2rgba8_half_cvt (
	input  pf2rgba8_pkg::comp_t  half_in,
	output pf2rgba8_pkg::byte_t  unorm_out
);

	logic                                      sign;
	logic [pf2rgba8_pkg::HALF_EXP_W-1:0]       expo;
	logic [pf2rgba8_pkg::HALF_MANT_W:0]        sig;
	logic [18:0]                               scaled;
	logic [24:0]                               rnd;
	logic [24:0]                               sum;
	logic [24:0]                               shifted;

	assign sign = half_in[15];
	assign expo = half_in[14:10];
	assign sig  = {1'b1, half_in[9:0]};

	// sig * 255
	assign scaled  = {sig, 8'd0} - {8'd0, sig};
	assign rnd     = 25'd1 << (5'd24 - expo);
	assign sum     = {6'd0, scaled} + rnd;
	assign shifted = sum >> (5'd25 - expo);

	always_comb begin
		if (expo == pf2rgba8_pkg::HALF_EXP_MAX) begin
			// inf gives full scale, NaN and -inf give zero
			unorm_out = (half_in[9:0] != '0 || sign) ? '0 : pf2rgba8_pkg::UNORM_MAX;
		end else if (sign) begin
			unorm_out = '0;
		end else if (expo >= pf2rgba8_pkg::HALF_EXP_ONE) begin
			unorm_out = pf2rgba8_pkg::UNORM_MAX;
		end else if (expo == '0) begin
			unorm_out = '0;
		end else begin
			unorm_out = shifted[7:0];
		end
	end

endmodule

[hdl/pf2rgba8_fmt_sel.sv]
// Per-format component selection: byte passthrough, red/blue swap, half-float convert or zero.
module pf2rgba8_fmt_sel (
	input  pf2rgba8_pkg::pix_fmt_t   pixel_format,
	input  pf2rgba8_pkg::pix_in_t    pix_in,
	output pf2rgba8_pkg::pix_out_t   pix_out
);

	pf2rgba8_pkg::byte_t  h0, h1, h2, h3;

	pf2rgba8_half_cvt u_cvt0 (.half_in(pix_in.comp0), .unorm_out(h0));
	pf2rgba8_half_cvt u_cvt1 (.half_in(pix_in.comp1), .unorm_out(h1));
	pf2rgba8_half_cvt u_cvt2 (.half_in(pix_in.comp2), .unorm_out(h2));
	pf2rgba8_half_cvt u_cvt3 (.half_in(pix_in.comp3), .unorm_out(h3));

	always_comb begin
		case (pixel_format)
			pf2rgba8_pkg::FMT_RGBA8: begin
				pix_out.red   = pix_in.comp0[7:0];
				pix_out.green = pix_in.comp1[7:0];
				pix_out.blue  = pix_in.comp2[7:0];
				pix_out.alpha = pix_in.comp3[7:0];
			end
			pf2rgba8_pkg::FMT_BGRA8: begin
				pix_out.red   = pix_in.comp2[7:0];
				pix_out.green = pix_in.comp1[7:0];
				pix_out.blue  = pix_in.comp0[7:0];
				pix_out.alpha = pix_in.comp3[7:0];
			end
			pf2rgba8_pkg::FMT_RGBA16F: begin
				pix_out.red   = h0;
				pix_out.green = h1;
				pix_out.blue  = h2;
				pix_out.alpha = h3;
			end
			default: begin
				pix_out = '0;
			end
		endcase
	end

endmodule

[hdl/pixel_format_to_rgba8_unit.sv]
// Top level of the pixel format to RGBA8 converter: stream pipeline and APB port.
//
// Takes one source pixel per beat and returns one RGBA8 pixel per beat. The
// source format (rgba8, bgra8 or four half-float components) comes from the
// pixel_format register at byte address 0, and must only be changed while no
// pixel is in flight. Throughput is one pixel per clock while m_axis_tready is
// high. An accepted pixel is held in the input register, then passes through the
// conversion logic into the output register, which drives m_axis_tvalid and
// m_axis_tdata. Each register advances as soon as the one after it is empty or
// being emptied, so bubbles close up; s_axis_tready drops only while both
// registers hold a pixel and m_axis_tready is low.
module pixel_format_to_rgba8_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pf2rgba8_pkg::PADDR_W-1:0]    paddr,
	input  logic [pf2rgba8_pkg::PDATA_W-1:0]    pwdata,
	output logic [pf2rgba8_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready,
	// source pixels
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pf2rgba8_pkg::IN_W-1:0]       s_axis_tdata,   // comp0, comp1, comp2, comp3
	// RGBA8 pixels
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [pf2rgba8_pkg::OUT_W-1:0]      m_axis_tdata    // red, green, blue, alpha
);

	pf2rgba8_pkg::pix_fmt_t   pixel_format;
	pf2rgba8_pkg::pix_in_t    pix_s1;
	pf2rgba8_pkg::pix_out_t   pix_cvt;
	pf2rgba8_pkg::pix_out_t   pix_s2;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     adv_s2;

	pf2rgba8_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_format (pixel_format)
	);

	pf2rgba8_fmt_sel u_sel (
		.pixel_format (pixel_format),
		.pix_in       (pix_s1),
		.pix_out      (pix_cvt)
	);

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pix_s1 <= pf2rgba8_pkg::pix_in_t'(s_axis_tdata);
		end
		if (valid_s1 && adv_s2) begin
			pix_s2 <= pix_cvt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = pix_s2;

`ifndef SYNTHESIS
	a_empty_never_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_accept_lands_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> valid_s1)
		else $error("accepted beat lost before stage 1");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("stage 1 beat lost before output register");

	a_out_held_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(pix_s1)))
		else $error("stage 1 beat changed during stall");
`endif

endmodule

[tb/pf2rgba8_checker.sv]
// Scoreboard for the RGBA8 converter: follows the format register, predicts each output pixel.
module pf2rgba8_checker
	import pf2rgba8_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic [PDATA_W-1:0]  prdata,
	input  logic                pready,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [IN_W-1:0]     s_axis_tdata,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [OUT_W-1:0]    m_axis_tdata,
	output int                  mismatches,
	output int                  pending
);

	localparam int unsigned HIDDEN_ONE = 1 << HALF_MANT_W;

	pix_fmt_t cur_fmt;
	pix_out_t expected_pixels[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		$display("%0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
		mismatches++;
	endtask

	// clamp to [0,1], scale by 255, round half up, all in fixed point
	function automatic byte_t half_to_byte(input comp_t h);
		logic                   neg;
		logic [HALF_EXP_W-1:0]  ex;
		logic [HALF_MANT_W-1:0] man;
		int unsigned            scaled;
		neg = h[COMP_W-1];
		ex  = h[HALF_MANT_W +: HALF_EXP_W];
		man = h[HALF_MANT_W-1:0];
		if (ex == HALF_EXP_MAX)
			return (man != '0 || neg) ? '0 : UNORM_MAX;
		if (neg)
			return '0;
		if (ex >= HALF_EXP_ONE)
			return UNORM_MAX;
		if (ex == '0)
			return '0;
		scaled = (HIDDEN_ONE + man) * UNORM_MAX;
		scaled = scaled + (32'd1 << (24 - ex));
		return byte_t'(scaled >> (25 - ex));
	endfunction

	function automatic pix_out_t convert_pixel(input pix_fmt_t f, input pix_in_t p);
		pix_out_t o;
		case (f)
			FMT_RGBA8: begin
				o.red   = p.comp0[BYTE_W-1:0];
				o.green = p.comp1[BYTE_W-1:0];
				o.blue  = p.comp2[BYTE_W-1:0];
				o.alpha = p.comp3[BYTE_W-1:0];
			end
			FMT_BGRA8: begin
				o.red   = p.comp2[BYTE_W-1:0];
				o.green = p.comp1[BYTE_W-1:0];
				o.blue  = p.comp0[BYTE_W-1:0];
				o.alpha = p.comp3[BYTE_W-1:0];
			end
			FMT_RGBA16F: begin
				o.red   = half_to_byte(p.comp0);
				o.green = half_to_byte(p.comp1);
				o.blue  = half_to_byte(p.comp2);
				o.alpha = half_to_byte(p.comp3);
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	task automatic check_pixel(input pix_out_t got);
		pix_out_t want;
		if (expected_pixels.size() == 0) begin
			report("unexpected output beat", 0, got);
			return;
		end
		want = expected_pixels.pop_front();
		if (got.red != want.red)
			report("red", want.red, got.red);
		if (got.green != want.green)
			report("green", want.green, got.green);
		if (got.blue != want.blue)
			report("blue", want.blue, got.blue);
		if (got.alpha != want.alpha)
			report("alpha", want.alpha, got.alpha);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_fmt = FMT_RGBA8;
			expected_pixels.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready &&
			    reg_idx_t'(paddr[PADDR_W-1:2]) == REG_PIXEL_FORMAT) begin
				if (pwrite)
					cur_fmt = pix_fmt_t'(pwdata[1:0]);
				else if (prdata != PDATA_W'(cur_fmt))
					report("pixel_format readback", cur_fmt, prdata);
			end
			if (m_axis_tvalid && m_axis_tready)
				check_pixel(pix_out_t'(m_axis_tdata));
			if (s_axis_tvalid && s_axis_tready)
				expected_pixels.push_back(convert_pixel(cur_fmt, pix_in_t'(s_axis_tdata)));
			pending = expected_pixels.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the converter testbench: clock, reset, APB and pixel stimulus, verdict.
module testbench;
	import pf2rgba8_pkg::*;

	localparam int NUM_HALF_CASES = 20;
	localparam int NUM_BYTE_CASES = 6;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               psel          = 1'b0;
	logic               penable       = 1'b0;
	logic               pwrite        = 1'b0;
	logic [PADDR_W-1:0] paddr         = '0;
	logic [PDATA_W-1:0] pwdata        = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata  = '0;   // comp0, comp1, comp2, comp3
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;         // red, green, blue, alpha

	int mismatches;
	int pending;
	int hold_cycles = 0;
	int burst_left  = 0;

	comp_t half_cases [0:NUM_HALF_CASES-1] = '{
		16'h0000, 16'h8000, 16'h0001, 16'h03ff, 16'h0400, 16'h1c00, 16'h2000,
		16'h2bff, 16'h3555, 16'h3800, 16'h3bff, 16'h3c00, 16'h3c01, 16'h7bff,
		16'h7c00, 16'hfc00, 16'h7e00, 16'hfe00, 16'h7c01, 16'hbc00
	};
	comp_t byte_cases [0:NUM_BYTE_CASES-1] = '{
		16'h0000, 16'hffff, 16'h00ff, 16'hff00, 16'ha55a, 16'h1234
	};

	pixel_format_to_rgba8_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pf2rgba8_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3_200_000;
		$display("Mismatches found");
		$finish;
	end

	// output side: segments of steady, random, periodic and sparse ready, plus long hold-offs
	initial begin : sink_ready
		int seg_left;
		int mode;
		int tick;
		seg_left = 0;
		mode     = 0;
		tick     = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(8, 64);
				end
				seg_left--;
				case (mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= (tick % 4 != 0);
					default: m_axis_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_pixel(input pix_in_t pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// mostly in-range halves, with steady doses of clamped, zero/subnormal and inf/NaN codes
	function automatic comp_t rand_half();
		comp_t h;
		h = comp_t'($urandom());
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				h[COMP_W-1] = 1'b0;
				h[HALF_MANT_W +: HALF_EXP_W] = HALF_EXP_W'($urandom_range(1, 14));
			end
			6: h[HALF_MANT_W +: HALF_EXP_W] = HALF_EXP_W'($urandom_range(15, 30));
			7: h[HALF_MANT_W +: HALF_EXP_W] = '0;
			8: begin
				h[HALF_MANT_W +: HALF_EXP_W] = HALF_EXP_MAX;
				if ($urandom_range(0, 1) == 0)
					h[HALF_MANT_W-1:0] = '0;
			end
			default: ;
		endcase
		return h;
	endfunction

	task automatic run_phase(input pix_fmt_t f, input int n_random, input bit do_directed,
			input bit program_reg, input bit with_hold);
		logic [PDATA_W-1:0] data;
		pix_in_t            pix;
		bit                 halves;
		int                 n_cases;
		halves = (f == FMT_RGBA16F);
		if (program_reg) begin
			data      = $urandom();
			data[1:0] = f;
			apb_access(1'b1, REG_PIXEL_FORMAT, data);
			apb_access(1'b1, REG_UNUSED, $urandom());
		end
		apb_access(1'b0, REG_PIXEL_FORMAT, '0);
		if (do_directed) begin
			n_cases = halves ? NUM_HALF_CASES : NUM_BYTE_CASES;
			for (int k = 0; k < n_cases; k++) begin
				for (int j = 0; j < NUM_COMP; j++)
					pix[j*COMP_W +: COMP_W] = halves ? half_cases[(k + j) % n_cases]
					                                 : byte_cases[(k + j) % n_cases];
				send_pixel(pix);
			end
		end
		for (int i = 0; i < n_random; i++) begin
			if (with_hold && i == n_random / 3)
				hold_cycles = 300;
			for (int j = 0; j < NUM_COMP; j++)
				pix[j*COMP_W +: COMP_W] = halves ? rand_half() : comp_t'($urandom());
			send_pixel(pix);
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_phase(FMT_RGBA8,   60,  1'b1, 1'b0, 1'b0);
		run_phase(FMT_BGRA8,   80,  1'b1, 1'b1, 1'b0);
		run_phase(FMT_RGBA16F, 200, 1'b1, 1'b1, 1'b1);
		run_phase(FMT_NONE,    40,  1'b0, 1'b1, 1'b0);
		run_phase(FMT_RGBA8,   60,  1'b0, 1'b1, 1'b1);
		run_phase(FMT_RGBA16F, 100, 1'b0, 1'b1, 1'b0);
		run_phase(FMT_BGRA8,   60,  1'b0, 1'b1, 1'b0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
